// ===== rtl/lkvc_pkg.sv =====
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_cell and lru_key_value_cache; depends on nothing else.
`timescale 1ns / 1ps

package lkvc_pkg;

    // Default sizes handed to the top-level parameters.
    localparam int DEPTH_DEF       = 16;
    localparam int KEY_WIDTH_DEF   = 32;
    localparam int VALUE_WIDTH_DEF = 32;

    // Configuration register layout.
    localparam int              CAP_W        = 5;
    localparam logic [CAP_W-1:0] CAP_RESET   = 5'd16;
    localparam int              PADDR_W      = 3;
    localparam int              PDATA_W      = 32;
    localparam logic            REG_CAPACITY = 1'b0;

    // Command codes.
    localparam logic CMD_LOOKUP = 1'b0;
    localparam logic CMD_INSERT = 1'b1;

    // Operation broadcast from the sequencer to every cell.
    typedef enum logic [1:0] {
        OP_NONE,
        OP_MATCH,
        OP_TOUCH,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     evict;
    } cell_ctrl_t;

endpackage

// ===== rtl/lru_key_value_cache.sv =====
// Top level of the fully associative LRU key-value cache.
// Depends on lkvc_pkg and a row of lkvc_cell entries.
`timescale 1ns / 1ps

// Usage:
// An item is taken on a rising edge with start high and busy low: command
// (0 lookup, 1 insert), key and value. Its result beat follows the compare
// and update cycles and is shown for one cycle, marked by done: hit, value_out
// and occupancy. busy is high from the accepting edge until the result beat,
// so a new item can be taken in the cycle in which done is shown, but never
// while the last item is still being compared or updated.
// The steps are: a compare cycle in which every cell checks its key and its
// victim rank in parallel, an update cycle in which the hit rank is gathered
// and each cell updates its rank, key and value, and the result beat.
// The free-slot choice ripples along the row of cells in the update cycle.
// The receiver cannot stall: each result is shown exactly once.
// Reset clears all valid bits and the occupancy and sets capacity_in_use to 16.
// capacity_in_use is written over the APB port at byte addresses 0 to 3 only.
// User must write it only while the block is idle; block does not enforce it.

module lru_key_value_cache #(
    parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF,
    parameter int CNT_W       = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    // Command channel.
    input  logic                         start,
    output logic                         busy,
    input  logic                         command,
    input  logic [KEY_WIDTH-1:0]         key,
    input  logic [VALUE_WIDTH-1:0]       value,
    // Result channel.
    output logic                         done,
    output logic                         hit,
    output logic [VALUE_WIDTH-1:0]       value_out,
    output logic [CNT_W-1:0]             occupancy,
    // Configuration port.
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkvc_pkg::PADDR_W-1:0] paddr,
    input  logic [lkvc_pkg::PDATA_W-1:0] pwdata,
    output logic [lkvc_pkg::PDATA_W-1:0] prdata,
    output logic                         pready
);
    import lkvc_pkg::*;

    localparam int RANK_W = $clog2(DEPTH);
    localparam int CMP_W  = (CNT_W > CAP_W) ? CNT_W + 1 : CAP_W + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE
    } state_t;

    state_t                 state_reg;
    logic                   cmd_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       count_next;
    logic [CAP_W-1:0]       cap_reg;
    logic                   done_reg;
    logic                   hit_reg;
    logic [VALUE_WIDTH-1:0] value_out_reg;
    logic [VALUE_WIDTH-1:0] value_out_next;
    logic [CNT_W-1:0]       occupancy_reg;

    cell_ctrl_t             ctrl;
    logic [RANK_W-1:0]      cmp_rank;
    logic [CNT_W-1:0]       count_m1;
    logic                   evict;
    logic                   any_hit;
    logic [RANK_W-1:0]      hit_rank;
    logic [VALUE_WIDTH-1:0] hit_value;
    logic                   cfg_write;

    logic [DEPTH:0]         claim;
    logic [DEPTH-1:0]       match_w;
    logic [DEPTH-1:0]       valid_w;
    logic [RANK_W-1:0]      rank_w  [DEPTH];
    logic [VALUE_WIDTH-1:0] value_w [DEPTH];

    // Configuration register.
    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg <= CAP_RESET;
        end
        else if (cfg_write && (paddr[PADDR_W-1] == REG_CAPACITY))
        begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    assign prdata = (paddr[PADDR_W-1] == REG_CAPACITY) ? PDATA_W'(cap_reg) : '0;

    // Gather the matching entry's rank and value; at most one cell matches.
    always_comb
    begin
        any_hit   = 1'b0;
        hit_rank  = '0;
        hit_value = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            any_hit   = any_hit | match_w[i];
            hit_rank  = hit_rank | (rank_w[i] & {RANK_W{match_w[i]}});
            hit_value = hit_value | (value_w[i] & {VALUE_WIDTH{match_w[i]}});
        end
    end

    // A zero capacity acts as one, a capacity above the depth as the depth.
    always_comb
    begin
        if (cap_reg == '0)
        begin
            evict = (count_reg != '0);
        end
        else
        begin
            evict = (CMP_W'(count_reg) >= CMP_W'(cap_reg)) ||
                    (count_reg == CNT_W'(DEPTH));
        end
    end

    // Broadcast to the cells: compare in the match cycle, then update.
    assign count_m1 = count_reg - CNT_W'(1);

    always_comb
    begin
        ctrl.op    = OP_NONE;
        ctrl.evict = 1'b0;
        cmp_rank   = count_m1[RANK_W-1:0];
        case (state_reg)
            S_MATCH:
            begin
                ctrl.op = OP_MATCH;
            end
            S_UPDATE:
            begin
                cmp_rank = hit_rank;
                if (any_hit)
                begin
                    if (cmd_reg == CMD_LOOKUP)
                    begin
                        ctrl.op = OP_TOUCH;
                    end
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    ctrl.op    = OP_INSERT;
                    ctrl.evict = evict;
                end
            end
            default:
            begin
            end
        endcase
    end

    // Occupancy and result value after the item.
    always_comb
    begin
        count_next     = count_reg;
        value_out_next = '0;
        if (any_hit)
        begin
            value_out_next = hit_value;
        end
        else if (cmd_reg == CMD_INSERT)
        begin
            value_out_next = value_reg;
            if (!evict)
            begin
                count_next = count_reg + CNT_W'(1);
            end
        end
    end

    // Row of cells with the free-slot claim chained from entry 0 upward.
    assign claim[0] = 1'b0;

    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        lkvc_cell #(
            .KEY_WIDTH   (KEY_WIDTH),
            .VALUE_WIDTH (VALUE_WIDTH),
            .RANK_W      (RANK_W)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .key_in    (key_reg),
            .value_in  (value_reg),
            .cmp_rank  (cmp_rank),
            .claim_in  (claim[g]),
            .claim_out (claim[g+1]),
            .match     (match_w[g]),
            .valid     (valid_w[g]),
            .rank      (rank_w[g]),
            .value_q   (value_w[g])
        );
    end

    // Sequencer with the occupancy count and the registered result beat.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            done_reg      <= 1'b0;
            hit_reg       <= 1'b0;
            occupancy_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= S_MATCH;
                    end
                end
                S_MATCH:
                begin
                    state_reg <= S_UPDATE;
                end
                S_UPDATE:
                begin
                    state_reg     <= S_IDLE;
                    count_reg     <= count_next;
                    done_reg      <= 1'b1;
                    hit_reg       <= any_hit;
                    occupancy_reg <= count_next;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // Item payload and result value.
    always_ff @(posedge clk)
    begin
        if ((state_reg == S_IDLE) && start)
        begin
            cmd_reg   <= command;
            key_reg   <= key;
            value_reg <= value;
        end
        if (state_reg == S_UPDATE)
        begin
            value_out_reg <= value_out_next;
        end
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign hit       = hit_reg;
    assign value_out = value_out_reg;
    assign occupancy = occupancy_reg;

    // Valid bits are kept per cell; the total is tracked in count_reg.
    logic unused_valid;
    assign unused_valid = ^valid_w ^ claim[DEPTH];

endmodule

// ===== rtl/lkvc_cell.sv =====
// One entry of the cache: key, value, recency rank and valid bit.
// Depends on lkvc_pkg; chained to its neighbors through the free-slot claim.
`timescale 1ns / 1ps

module lkvc_cell #(
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF,
    parameter int RANK_W      = 4
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  lkvc_pkg::cell_ctrl_t    ctrl,
    input  logic [KEY_WIDTH-1:0]    key_in,
    input  logic [VALUE_WIDTH-1:0]  value_in,
    input  logic [RANK_W-1:0]       cmp_rank,
    input  logic                    claim_in,
    output logic                    claim_out,
    output logic                    match,
    output logic                    valid,
    output logic [RANK_W-1:0]       rank,
    output logic [VALUE_WIDTH-1:0]  value_q
);
    import lkvc_pkg::*;

    logic                   valid_reg;
    logic                   valid_next;
    logic                   match_reg;
    logic                   victim_reg;
    logic [KEY_WIDTH-1:0]   key_reg;
    logic [KEY_WIDTH-1:0]   key_next;
    logic [VALUE_WIDTH-1:0] value_reg;
    logic [VALUE_WIDTH-1:0] value_next;
    logic [RANK_W-1:0]      rank_reg;
    logic [RANK_W-1:0]      rank_next;
    logic                   valid_after;
    logic                   take;

    // An evicted victim frees its slot before the free-slot claim runs.
    assign valid_after = valid_reg & ~(ctrl.evict & victim_reg);

    // The lowest free cell takes the new key; higher cells see the claim.
    assign take      = ~valid_after & ~claim_in;
    assign claim_out = claim_in | ~valid_after;

    // Next state of the entry for the broadcast operation.
    always_comb
    begin
        valid_next = valid_reg;
        key_next   = key_reg;
        value_next = value_reg;
        rank_next  = rank_reg;
        case (ctrl.op)
            OP_TOUCH:
            begin
                if (match_reg)
                begin
                    rank_next = '0;
                end
                else if (valid_reg && (rank_reg < cmp_rank))
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            OP_INSERT:
            begin
                valid_next = valid_after;
                if (take)
                begin
                    valid_next = 1'b1;
                    key_next   = key_in;
                    value_next = value_in;
                    rank_next  = '0;
                end
                else if (valid_after)
                begin
                    rank_next = rank_reg + RANK_W'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control flags of the entry.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= 1'b0;
            match_reg  <= 1'b0;
            victim_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (ctrl.op == OP_MATCH)
            begin
                match_reg  <= valid_reg && (key_reg == key_in);
                victim_reg <= valid_reg && (rank_reg == cmp_rank);
            end
        end
    end

    // Payload of the entry; only read while the entry is valid.
    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
        rank_reg  <= rank_next;
    end

    assign match   = match_reg;
    assign valid   = valid_reg;
    assign rank    = rank_reg;
    assign value_q = value_reg;

endmodule

// ===== sim/lkvc_checker.sv =====
// Result checker for the LRU key-value cache: watches the command, result and APB channels.
// Keeps its own copy of the cache contents, recency order and capacity register.
// Depends on lkvc_pkg for the command codes and register layout.
`timescale 1ns / 1ps

module lkvc_checker #(
    parameter int DEPTH       = lkvc_pkg::DEPTH_DEF,
    parameter int KEY_WIDTH   = lkvc_pkg::KEY_WIDTH_DEF,
    parameter int VALUE_WIDTH = lkvc_pkg::VALUE_WIDTH_DEF,
    parameter int OCC_W       = $clog2(DEPTH + 1)
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic                         busy,
    input  logic                         command,
    input  logic [KEY_WIDTH-1:0]         key,
    input  logic [VALUE_WIDTH-1:0]       value,
    input  logic                         done,
    input  logic                         hit,
    input  logic [VALUE_WIDTH-1:0]       value_out,
    input  logic [OCC_W-1:0]             occupancy,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [lkvc_pkg::PADDR_W-1:0] paddr,
    input  logic [lkvc_pkg::PDATA_W-1:0] pwdata,
    input  logic [lkvc_pkg::PDATA_W-1:0] prdata,
    input  logic                         pready,
    output int                           mismatch_count,
    output int                           outstanding
);

    import lkvc_pkg::*;

    localparam logic [PADDR_W-1:0] CAP_ADDR = PADDR_W'(4 * int'(REG_CAPACITY));
    localparam int                 REPORT_LIMIT = 10;

    typedef struct packed {
        logic                   hit;
        logic [VALUE_WIDTH-1:0] value;
        logic [OCC_W-1:0]       occ;
    } access_outcome_t;

    // Mirror of the cache contents.
    logic                   line_valid [DEPTH];
    logic [KEY_WIDTH-1:0]   line_key   [DEPTH];
    logic [VALUE_WIDTH-1:0] line_value [DEPTH];
    int                     line_age   [DEPTH];
    int                     line_count;
    logic [CAP_W-1:0]       capacity_reg;

    access_outcome_t awaited_outcomes [$];

    // Applies one command to the mirror and returns the result beat it should produce.
    function automatic access_outcome_t cache_access_outcome(input logic cmd,
                                                             input logic [KEY_WIDTH-1:0] k,
                                                             input logic [VALUE_WIDTH-1:0] v);
        access_outcome_t res;
        int found;
        int victim;
        int slot;
        int limit;
        int old_age;
        res    = '0;
        found  = -1;
        victim = -1;
        slot   = -1;
        limit  = (capacity_reg == 0) ? 1 : ((capacity_reg > DEPTH) ? DEPTH : capacity_reg);
        for (int i = 0; i < DEPTH; i++)
        begin
            if (found < 0 && line_valid[i] && line_key[i] == k)
                found = i;
        end
        if (found >= 0)
        begin
            res.hit   = 1'b1;
            res.value = line_value[found];
            // Only a lookup refreshes recency; an insert of a present key leaves it alone.
            if (cmd == CMD_LOOKUP)
            begin
                old_age = line_age[found];
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (line_valid[i] && line_age[i] < old_age)
                        line_age[i]++;
                end
                line_age[found] = 0;
            end
        end
        else if (cmd == CMD_INSERT)
        begin
            // At or above capacity, exactly one least recent line goes first.
            if (line_count >= limit && line_count > 0)
            begin
                for (int i = 0; i < DEPTH; i++)
                begin
                    if (line_valid[i] && (victim < 0 || line_age[i] > line_age[victim]))
                        victim = i;
                end
                if (victim >= 0)
                begin
                    line_valid[victim] = 1'b0;
                    line_count--;
                end
            end
            for (int i = 0; i < DEPTH; i++)
            begin
                if (line_valid[i])
                    line_age[i]++;
            end
            // The new key lands in the lowest free line.
            for (int i = 0; i < DEPTH; i++)
            begin
                if (slot < 0 && !line_valid[i])
                    slot = i;
            end
            if (slot >= 0)
            begin
                line_valid[slot] = 1'b1;
                line_key[slot]   = k;
                line_value[slot] = v;
                line_age[slot]   = 0;
                line_count++;
            end
            res.value = v;
        end
        res.occ = OCC_W'(line_count);
        return res;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
            $display("%0t ns: mismatch: %s", $realtime, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        access_outcome_t want;
        access_outcome_t got;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                line_valid[i] = 1'b0;
                line_key[i]   = '0;
                line_value[i] = '0;
                line_age[i]   = 0;
            end
            line_count     = 0;
            capacity_reg   = CAP_RESET;
            mismatch_count = 0;
            awaited_outcomes.delete();
            outstanding <= 0;
        end
        else
        begin
            // Register port: track writes, check read data.
            if (psel && penable && pready && paddr == CAP_ADDR)
            begin
                if (pwrite)
                    capacity_reg = pwdata[CAP_W-1:0];
                else if (prdata !== PDATA_W'(capacity_reg))
                    flag_mismatch($sformatf("capacity read expected %0d got %h",
                                            capacity_reg, prdata));
            end

            // Result beat against the oldest prediction.
            if (done)
            begin
                got = '{hit: hit, value: value_out, occ: occupancy};
                if (awaited_outcomes.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected result hit=%b value=%h occ=%0d",
                                            hit, value_out, occupancy));
                end
                else
                begin
                    want = awaited_outcomes[0];
                    awaited_outcomes.delete(0);
                    if (got.hit !== want.hit || got.value !== want.value
                        || got.occ !== want.occ)
                        flag_mismatch($sformatf(
                            "expected hit=%b value=%h occ=%0d, got hit=%b value=%h occ=%0d",
                            want.hit, want.value, want.occ, got.hit, got.value, got.occ));
                end
            end

            // Command beat accepted at this edge.
            if (start && !busy)
                awaited_outcomes = {awaited_outcomes, cache_access_outcome(command, key, value)};

            outstanding <= awaited_outcomes.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for lru_key_value_cache: clock, reset, command and APB stimulus, verdict.
// Depends on lkvc_pkg, the lru_key_value_cache RTL and the lkvc_checker module.
`timescale 1ns / 1ps

module tb;

    import lkvc_pkg::*;

    localparam int DEPTH       = DEPTH_DEF;
    localparam int KW          = KEY_WIDTH_DEF;
    localparam int VW          = VALUE_WIDTH_DEF;
    localparam int OCC_W       = $clog2(DEPTH + 1);
    localparam int CYCLE_LIMIT = 200000;
    localparam int PHASE_ITEMS = 125;

    localparam logic [PADDR_W-1:0] CAP_ADDR   = PADDR_W'(4 * int'(REG_CAPACITY));
    localparam logic [PADDR_W-1:0] SPARE_ADDR = PADDR_W'(4 * (int'(REG_CAPACITY) + 1));

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 start     = 1'b0;
    logic                 command   = CMD_LOOKUP;
    logic [KW-1:0]        key       = '0;
    logic [VW-1:0]        value     = '0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [PADDR_W-1:0]   paddr     = '0;
    logic [PDATA_W-1:0]   pwdata    = '0;
    logic                 busy;
    logic                 done;
    logic                 hit;
    logic [VW-1:0]        value_out;
    logic [OCC_W-1:0]     occupancy;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;
    int                   mismatch_count;
    int                   outstanding;
    int                   cycle_count = 0;

    logic [KW-1:0]        key_pool [$];

    lru_key_value_cache dut (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .command(command), .key(key), .value(value),
        .done(done), .hit(hit), .value_out(value_out), .occupancy(occupancy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    lkvc_checker #(.DEPTH(DEPTH), .KEY_WIDTH(KW), .VALUE_WIDTH(VW), .OCC_W(OCC_W))
    result_checker (
        .clk(clk), .rst_n(rst_n),
        .start(start), .busy(busy), .command(command), .key(key), .value(value),
        .done(done), .hit(hit), .value_out(value_out), .occupancy(occupancy),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .mismatch_count(mismatch_count), .outstanding(outstanding)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Presents one command beat and holds it until the block takes it.
    task automatic send_item(input logic cmd, input logic [KW-1:0] k, input logic [VW-1:0] v);
        start   <= 1'b1;
        command <= cmd;
        key     <= k;
        value   <= v;
        do @(posedge clk); while (busy);
    endtask

    task automatic hold_off(input int cycles);
        start <= 1'b0;
        repeat (cycles) @(posedge clk);
    endtask

    // Stops sending and waits until every predicted result beat has arrived.
    task automatic drain;
        start <= 1'b0;
        do @(posedge clk); while (outstanding != 0 || busy);
        repeat (4) @(posedge clk);
    endtask

    // Setup cycle, access cycle, then the port is released and left idle.
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Writes the capacity with junk in the unused upper bits, then reads it back.
    task automatic set_capacity(input logic [CAP_W-1:0] cap);
        logic [PDATA_W-1:0] word;
        word = $urandom;
        word[CAP_W-1:0] = cap;
        drain();
        apb_access(1'b1, CAP_ADDR, word);
        apb_access(1'b0, CAP_ADDR, '0);
    endtask

    function automatic logic [VW-1:0] pick_value;
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return '0;
        if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // A phase of random traffic over a key pool a little larger than the capacity,
    // so hits, misses and evictions all happen.
    task automatic random_phase(input int items, input logic [CAP_W-1:0] cap);
        int limit;
        int sent;
        int burst;
        int gap_pick;
        logic [KW-1:0] k;
        limit = (cap == 0) ? 1 : ((cap > DEPTH) ? DEPTH : cap);
        key_pool.delete();
        for (int i = 0; i < limit + $urandom_range(1, 6); i++)
        begin
            case ($urandom_range(0, 15))
                0:       k = '0;
                1:       k = '1;
                default: k = $urandom;
            endcase
            key_pool = {key_pool, k};
        end
        sent = 0;
        while (sent < items)
        begin
            burst = $urandom_range(1, 12);
            for (int b = 0; b < burst && sent < items; b++)
            begin
                if ($urandom_range(0, 19) < 17)
                    k = key_pool[$urandom_range(0, key_pool.size() - 1)];
                else
                    k = $urandom;
                send_item($urandom_range(0, 1) ? CMD_INSERT : CMD_LOOKUP, k, pick_value());
                sent++;
            end
            gap_pick = $urandom_range(0, 19);
            if (gap_pick >= 18)
                drain();
            else if (gap_pick >= 7)
                hold_off($urandom_range(1, 6));
        end
    endtask

    initial
    begin
        logic [CAP_W-1:0] cap_plan [$];
        cap_plan = '{5'd4, 5'd1, 5'd0, 5'd31, 5'd17, 5'd2, 5'd16, 5'd8};
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // Directed: extreme keys and values, hit and miss, present-key insert,
        // fill to capacity, then one eviction of the least recent line.
        send_item(CMD_LOOKUP, '0, '1);
        send_item(CMD_INSERT, '0, '1);
        send_item(CMD_INSERT, '1, '0);
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_INSERT, '0, 32'h1234_5678);
        send_item(CMD_LOOKUP, '1, '1);
        send_item(CMD_LOOKUP, 32'h0000_0005, '0);
        for (int i = 0; i < DEPTH - 2; i++)
            send_item(CMD_INSERT, KW'(32'h100 + i), $urandom);
        send_item(CMD_INSERT, 32'hA5A5_5A5A, 32'h5A5A_A5A5);
        send_item(CMD_LOOKUP, '0, '0);
        send_item(CMD_LOOKUP, '1, '0);
        drain();

        // A write to an unmapped address must leave the capacity alone.
        apb_access(1'b1, SPARE_ADDR, $urandom);
        apb_access(1'b0, CAP_ADDR, '0);

        // First plan entry drops the capacity below the current occupancy.
        foreach (cap_plan[i])
        begin
            set_capacity(cap_plan[i]);
            random_phase(PHASE_ITEMS, cap_plan[i]);
        end
        for (int i = 0; i < 2; i++)
        begin
            cap_plan[0] = $urandom_range(0, 31);
            set_capacity(cap_plan[0]);
            random_phase(PHASE_ITEMS, cap_plan[0]);
        end

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/lkvc_pkg.sv
rtl/lkvc_cell.sv
rtl/lru_key_value_cache.sv
sim/lkvc_checker.sv
sim/tb.sv
